>>> src/hhc_pkg.sv
// ----------------------------------------------------------------------------
// hhc_pkg
// Shared constants and types for the value to hue heat-map color pipeline.
// ----------------------------------------------------------------------------
package hhc_pkg;

   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int CHANNEL_BITS_DEF = 8;

   // The normalized fraction and the hue are unsigned Q0.16 values.
   localparam int FRAC_BITS = 16;
   localparam logic [FRAC_BITS:0]   ONE_Q      = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS-1:0] HUE_BLUE_Q = 16'd43647;

   localparam int RANGE_LOW_RESET  = 0;
   localparam int RANGE_HIGH_RESET = 32767;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH = 1'b1;

   typedef enum logic [1:0] {
      MODE_DIVIDE,
      MODE_ZERO,
      MODE_ONE,
      MODE_GRAY
   } mode_type;

endpackage

>>> src/hhc_front.sv
// ----------------------------------------------------------------------------
// hhc_front
// Range check stage: classifies a request against the range registers and
// forms the dividend and divisor of the normalization.
// ----------------------------------------------------------------------------
module hhc_front #(
   parameter int SAMPLE_BITS = hhc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic signed [SAMPLE_BITS-1:0] range_low,
   input  logic signed [SAMPLE_BITS-1:0] range_high,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hhc_pkg::mode_type             out_mode,
   output logic [SAMPLE_BITS:0]          out_num,
   output logic [SAMPLE_BITS:0]          out_den
);

   logic signed [SAMPLE_BITS:0] sample_ext;
   logic signed [SAMPLE_BITS:0] low_ext;
   logic signed [SAMPLE_BITS:0] high_ext;
   hhc_pkg::mode_type           mode_in;
   hhc_pkg::mode_type           mode_ff;
   logic [SAMPLE_BITS:0]        num_in;
   logic [SAMPLE_BITS:0]        num_ff;
   logic [SAMPLE_BITS:0]        den_in;
   logic [SAMPLE_BITS:0]        den_ff;
   logic                        valid_ff;

   assign sample_ext = {in_sample[SAMPLE_BITS-1], in_sample};
   assign low_ext    = {range_low[SAMPLE_BITS-1], range_low};
   assign high_ext   = {range_high[SAMPLE_BITS-1], range_high};
   assign num_in     = sample_ext - low_ext;
   assign den_in     = high_ext - low_ext;

   always_comb begin
      priority if (high_ext <= low_ext) begin
         mode_in = hhc_pkg::MODE_GRAY;
      end else if (sample_ext <= low_ext) begin
         mode_in = hhc_pkg::MODE_ZERO;
      end else if (sample_ext >= high_ext) begin
         mode_in = hhc_pkg::MODE_ONE;
      end else begin
         mode_in = hhc_pkg::MODE_DIVIDE;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         mode_ff <= mode_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mode  = mode_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

>>> src/hhc_div_stage.sv
// ----------------------------------------------------------------------------
// hhc_div_stage
// One restoring division step: develops one quotient bit of the normalized
// fraction per register stage.
// ----------------------------------------------------------------------------
module hhc_div_stage #(
   parameter int SAMPLE_BITS = hhc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  hhc_pkg::mode_type                in_mode,
   input  logic [SAMPLE_BITS:0]             in_rem,
   input  logic [SAMPLE_BITS:0]             in_den,
   input  logic [hhc_pkg::FRAC_BITS-1:0]    in_quot,
   output logic                             out_valid,
   input  logic                             out_ready,
   output hhc_pkg::mode_type                out_mode,
   output logic [SAMPLE_BITS:0]             out_rem,
   output logic [SAMPLE_BITS:0]             out_den,
   output logic [hhc_pkg::FRAC_BITS-1:0]    out_quot
);

   logic [SAMPLE_BITS+1:0]            shifted;
   logic [SAMPLE_BITS+1:0]            diff;
   logic                              fits;
   logic [SAMPLE_BITS:0]              rem_in;
   logic [hhc_pkg::FRAC_BITS-1:0]     quot_in;
   logic                              valid_ff;
   hhc_pkg::mode_type                 mode_ff;
   logic [SAMPLE_BITS:0]              rem_ff;
   logic [SAMPLE_BITS:0]              den_ff;
   logic [hhc_pkg::FRAC_BITS-1:0]     quot_ff;

   assign shifted = {in_rem, 1'b0};
   assign diff    = shifted - {1'b0, in_den};
   assign fits    = shifted >= {1'b0, in_den};
   assign rem_in  = fits ? diff[SAMPLE_BITS:0] : shifted[SAMPLE_BITS:0];
   assign quot_in = {in_quot[hhc_pkg::FRAC_BITS-2:0], fits};

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         mode_ff <= in_mode;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mode  = mode_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quot  = quot_ff;

endmodule

>>> src/hhc_hue.sv
// ----------------------------------------------------------------------------
// hhc_hue
// Two register stages: the hue product from the normalized fraction, then
// the sector and the rising or falling ramp value of the six-sector rule.
// ----------------------------------------------------------------------------
module hhc_hue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  hhc_pkg::mode_type              in_mode,
   input  logic [hhc_pkg::FRAC_BITS-1:0]  in_quot,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_gray,
   output logic [2:0]                     out_sector,
   output logic [hhc_pkg::FRAC_BITS:0]    out_x
);

   localparam int FB = hhc_pkg::FRAC_BITS;

   logic [FB:0]     frac;
   logic [FB:0]     inv;
   logic [2*FB:0]   prod;
   logic            ready1;
   logic            valid1_ff;
   logic            gray1_ff;
   logic [FB-1:0]   hue_ff;
   logic [FB+2:0]   h6;
   logic [2:0]      sector_in;
   logic [FB:0]     f_ext;
   logic [FB:0]     x_in;
   logic            ready2;
   logic            valid2_ff;
   logic            gray2_ff;
   logic [2:0]      sector_ff;
   logic [FB:0]     x_ff;

   always_comb begin
      unique case (in_mode)
         hhc_pkg::MODE_ZERO: frac = '0;
         hhc_pkg::MODE_ONE:  frac = hhc_pkg::ONE_Q;
         default:            frac = {1'b0, in_quot};
      endcase
   end

   assign inv  = hhc_pkg::ONE_Q - frac;
   assign prod = (2*FB+1)'(inv) * (2*FB+1)'(hhc_pkg::HUE_BLUE_Q);

   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (ready1) begin
         valid1_ff <= in_valid;
      end
      if (in_valid && ready1) begin
         gray1_ff <= (in_mode == hhc_pkg::MODE_GRAY);
         hue_ff   <= prod[2*FB-1:FB];
      end
   end

   assign h6        = {1'b0, hue_ff, 2'b00} + {2'b00, hue_ff, 1'b0};
   assign sector_in = h6[FB+2:FB];
   assign f_ext     = {1'b0, h6[FB-1:0]};
   assign x_in      = sector_in[0] ? (hhc_pkg::ONE_Q - f_ext) : f_ext;

   assign ready2 = !valid2_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (ready2) begin
         valid2_ff <= valid1_ff;
      end
      if (valid1_ff && ready2) begin
         gray2_ff  <= gray1_ff;
         sector_ff <= sector_in;
         x_ff      <= x_in;
      end
   end

   assign out_valid  = valid2_ff;
   assign out_gray   = gray2_ff;
   assign out_sector = sector_ff;
   assign out_x      = x_ff;

endmodule

>>> src/hhc_color.sv
// ----------------------------------------------------------------------------
// hhc_color
// Output stage: scales the ramp value to the channel width and places the
// full, ramp and zero parts on red, green and blue by sector, or mid gray on all three for a gray result.
// ----------------------------------------------------------------------------
module hhc_color #(
   parameter int CHANNEL_BITS = hhc_pkg::CHANNEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_gray,
   input  logic [2:0]                    in_sector,
   input  logic [hhc_pkg::FRAC_BITS:0]   in_x,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [CHANNEL_BITS-1:0]       out_red,
   output logic [CHANNEL_BITS-1:0]       out_green,
   output logic [CHANNEL_BITS-1:0]       out_blue
);

   localparam int FB = hhc_pkg::FRAC_BITS;
   localparam int PW = FB + CHANNEL_BITS + 1;
   localparam logic [CHANNEL_BITS-1:0] FULL      = '1;
   localparam logic [CHANNEL_BITS-1:0] MID_GRAY  = {1'b1, {(CHANNEL_BITS-1){1'b0}}};
   localparam logic [PW-1:0]           HALF      = PW'(1) << (FB - 1);

   logic [PW-1:0]           scaled_sum;
   logic [CHANNEL_BITS-1:0] ramp;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;
   logic                    valid_ff;
   logic [CHANNEL_BITS-1:0] red_ff;
   logic [CHANNEL_BITS-1:0] green_ff;
   logic [CHANNEL_BITS-1:0] blue_ff;

   assign scaled_sum = PW'(in_x) * PW'(FULL) + HALF;
   assign ramp       = scaled_sum[FB+CHANNEL_BITS-1:FB];

   always_comb begin
      if (in_gray) begin
         red_in   = MID_GRAY;
         green_in = MID_GRAY;
         blue_in  = MID_GRAY;
      end else begin
         unique case (in_sector)
            3'd0: begin
               red_in = FULL;  green_in = ramp;  blue_in = '0;
            end
            3'd1: begin
               red_in = ramp;  green_in = FULL;  blue_in = '0;
            end
            3'd2: begin
               red_in = '0;    green_in = FULL;  blue_in = ramp;
            end
            3'd3: begin
               red_in = '0;    green_in = ramp;  blue_in = FULL;
            end
            3'd4: begin
               red_in = ramp;  green_in = '0;    blue_in = FULL;
            end
            default: begin
               red_in = FULL;  green_in = '0;    blue_in = ramp;
            end
         endcase
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

>>> src/value_to_hue_heatmap_color.sv
// ----------------------------------------------------------------------------
// value_to_hue_heatmap_color
// Maps a signed sample onto a blue to red heat-map color. The sample is
// normalized against the range registers by a pipelined restoring divider,
// turned into a hue and passed through the six-sector HSV to RGB rule.
// ----------------------------------------------------------------------------
// A request passes through the range check stage, the divider stages, the hue stages and the color stage.
// Throughput: one request per cycle while the response side is not stalled; one pipeline register stage per
// quotient bit of the 16-bit normalization sets the depth.
// Each stage holds its own valid bit, so bubbles are filled during a stall.
// Reset clears all valid bits and sets range_low to 0, range_high to 32767.
// ----------------------------------------------------------------------------
module value_to_hue_heatmap_color #(
   parameter int SAMPLE_BITS  = hhc_pkg::SAMPLE_BITS_DEF,
   parameter int CHANNEL_BITS = hhc_pkg::CHANNEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [hhc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [SAMPLE_BITS-1:0]              csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [CHANNEL_BITS-1:0]             rsp_red,
   output logic [CHANNEL_BITS-1:0]             rsp_green,
   output logic [CHANNEL_BITS-1:0]             rsp_blue
);

   localparam int FB    = hhc_pkg::FRAC_BITS;
   localparam int NDIV  = hhc_pkg::FRAC_BITS;
   localparam logic [SAMPLE_BITS-1:0] LOW_RST  = SAMPLE_BITS'(hhc_pkg::RANGE_LOW_RESET);
   localparam logic [SAMPLE_BITS-1:0] HIGH_RST = SAMPLE_BITS'(hhc_pkg::RANGE_HIGH_RESET);

   logic [SAMPLE_BITS-1:0] range_low_ff;
   logic [SAMPLE_BITS-1:0] range_high_ff;

   logic                   div_valid [0:NDIV];
   logic                   div_ready [0:NDIV];
   hhc_pkg::mode_type      div_mode  [0:NDIV];
   logic [SAMPLE_BITS:0]   div_rem   [0:NDIV];
   logic [SAMPLE_BITS:0]   div_den   [0:NDIV];
   logic [FB-1:0]          div_quot  [0:NDIV];

   logic                   hue_valid;
   logic                   hue_ready;
   logic                   hue_gray;
   logic [2:0]             hue_sector;
   logic [FB:0]            hue_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= LOW_RST;
         range_high_ff <= HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            hhc_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            hhc_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   hhc_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_sample  (req_sample),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .out_valid  (div_valid[0]),
      .out_ready  (div_ready[0]),
      .out_mode   (div_mode[0]),
      .out_num    (div_rem[0]),
      .out_den    (div_den[0])
   );

   assign div_quot[0] = '0;

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      hhc_div_stage #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_mode   (div_mode[k]),
         .in_rem    (div_rem[k]),
         .in_den    (div_den[k]),
         .in_quot   (div_quot[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_mode  (div_mode[k+1]),
         .out_rem   (div_rem[k+1]),
         .out_den   (div_den[k+1]),
         .out_quot  (div_quot[k+1])
      );
   end

   hhc_hue u_hue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid[NDIV]),
      .in_ready   (div_ready[NDIV]),
      .in_mode    (div_mode[NDIV]),
      .in_quot    (div_quot[NDIV]),
      .out_valid  (hue_valid),
      .out_ready  (hue_ready),
      .out_gray   (hue_gray),
      .out_sector (hue_sector),
      .out_x      (hue_x)
   );

   hhc_color #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hue_valid),
      .in_ready  (hue_ready),
      .in_gray   (hue_gray),
      .in_sector (hue_sector),
      .in_x      (hue_x),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

>>> src/hhc_checker.sv
// ----------------------------------------------------------------------------
// hhc_checker
// Port-level checks for the heat-map color pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module hhc_checker #(
   parameter int CHANNEL_BITS = hhc_pkg::CHANNEL_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [CHANNEL_BITS-1:0] rsp_red,
   input logic [CHANNEL_BITS-1:0] rsp_green,
   input logic [CHANNEL_BITS-1:0] rsp_blue
);

   localparam logic [CHANNEL_BITS-1:0] FULL     = '1;
   localparam logic [CHANNEL_BITS-1:0] MID_GRAY = {1'b1, {(CHANNEL_BITS-1){1'b0}}};

   logic is_gray;
   logic has_full;
   logic has_zero;

   assign is_gray  = (rsp_red == MID_GRAY) && (rsp_green == MID_GRAY)
                     && (rsp_blue == MID_GRAY);
   assign has_full = (rsp_red == FULL) || (rsp_green == FULL) || (rsp_blue == FULL);
   assign has_zero = (rsp_red == '0) || (rsp_green == '0) || (rsp_blue == '0);

   // No response may come out of the cycle after a reset.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An empty pipeline output means every stage can take a request.
   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request not ready while the response side is empty");

   // A fully saturated color has one full and one zero channel, unless gray.
   a_color_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_gray || (has_full && has_zero)))
      else $error("response color is neither gray nor fully saturated");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled response payload changed");

endmodule

bind value_to_hue_heatmap_color hhc_checker #(
   .CHANNEL_BITS (CHANNEL_BITS)
) u_hhc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);

>>> verif/value_to_hue_heatmap_color_checker.sv
// ----------------------------------------------------------------------------
// value_to_hue_heatmap_color_checker
// Watches the range register writes and both handshake channels of the
// heat-map color block. It computes the color for every accepted request
// from its own copy of the range registers. Each returned color is compared
// channel by channel with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module value_to_hue_heatmap_color_checker
   import hhc_pkg::*;
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [CSR_INDEX_BITS-1:0]          csr_index,
   input  logic [SAMPLE_BITS_DEF-1:0]         csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [SAMPLE_BITS_DEF-1:0]  req_sample,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [CHANNEL_BITS_DEF-1:0]        rsp_red,
   input  logic [CHANNEL_BITS_DEF-1:0]        rsp_green,
   input  logic [CHANNEL_BITS_DEF-1:0]        rsp_blue,
   output int                                 errors,
   output int                                 pending,
   output int                                 colored,
   output int                                 grays
);

   typedef struct packed {
      logic [CHANNEL_BITS_DEF-1:0] red;
      logic [CHANNEL_BITS_DEF-1:0] green;
      logic [CHANNEL_BITS_DEF-1:0] blue;
   } color_type;

   logic signed [SAMPLE_BITS_DEF-1:0] scale_low;
   logic signed [SAMPLE_BITS_DEF-1:0] scale_high;
   color_type                         expected_colors[$];
   int                                mismatch_count;
   int                                checked_count;
   int                                gray_count;

   function automatic logic [CHANNEL_BITS_DEF-1:0] channel_level(input longint part);
      longint full;
      full = (longint'(1) << CHANNEL_BITS_DEF) - 1;
      return CHANNEL_BITS_DEF'((part * full + 32768) >> 16);
   endfunction

   function automatic color_type heat_color(input logic signed [SAMPLE_BITS_DEF-1:0] value,
                                            input logic signed [SAMPLE_BITS_DEF-1:0] lo,
                                            input logic signed [SAMPLE_BITS_DEF-1:0] hi);
      color_type c;
      longint unit;
      longint frac;
      longint hue;
      longint h6;
      longint f;
      longint x;
      longint r;
      longint g;
      longint b;
      int     sector;
      unit = longint'(ONE_Q);
      if (hi <= lo) begin
         c.red   = CHANNEL_BITS_DEF'(1) << (CHANNEL_BITS_DEF - 1);
         c.green = c.red;
         c.blue  = c.red;
         return c;
      end
      if (value <= lo) begin
         frac = 0;
      end else if (value >= hi) begin
         frac = unit;
      end else begin
         frac = ((longint'(value) - longint'(lo)) * unit) / (longint'(hi) - longint'(lo));
      end
      hue    = ((unit - frac) * longint'(HUE_BLUE_Q)) >> 16;
      h6     = hue * 6;
      sector = int'(h6 >> 16);
      f      = h6 & (unit - 1);
      x      = sector[0] ? unit - f : f;
      case (sector)
         0: begin
            r = unit; g = x;    b = 0;
         end
         1: begin
            r = x;    g = unit; b = 0;
         end
         2: begin
            r = 0;    g = unit; b = x;
         end
         3: begin
            r = 0;    g = x;    b = unit;
         end
         4: begin
            r = x;    g = 0;    b = unit;
         end
         default: begin
            r = unit; g = 0;    b = x;
         end
      endcase
      c.red   = channel_level(r);
      c.green = channel_level(g);
      c.blue  = channel_level(b);
      return c;
   endfunction

   always @(posedge clock) begin
      color_type want;
      if (reset) begin
         scale_low  = SAMPLE_BITS_DEF'(RANGE_LOW_RESET);
         scale_high = SAMPLE_BITS_DEF'(RANGE_HIGH_RESET);
         expected_colors.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("Color returned with no request outstanding.");
               mismatch_count++;
            end else begin
               want = expected_colors.pop_front();
               checked_count++;
               if (rsp_red !== want.red) begin
                  $error("red mismatch: expected %0d, got %0d", want.red, rsp_red);
                  mismatch_count++;
               end
               if (rsp_green !== want.green) begin
                  $error("green mismatch: expected %0d, got %0d", want.green, rsp_green);
                  mismatch_count++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue mismatch: expected %0d, got %0d", want.blue, rsp_blue);
                  mismatch_count++;
               end
            end
         end
         // A request sees the range registers as they were before this edge.
         if (req_valid && req_ready) begin
            expected_colors = {expected_colors,
                               heat_color(req_sample, scale_low, scale_high)};
            if (scale_high <= scale_low) begin
               gray_count++;
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_RANGE_LOW) begin
               scale_low = csr_wdata;
            end else if (csr_index == CSR_RANGE_HIGH) begin
               scale_high = csr_wdata;
            end
         end
      end
      errors  <= mismatch_count;
      pending <= expected_colors.size();
      colored <= checked_count;
      grays   <= gray_count;
   end

endmodule

>>> verif/value_to_hue_heatmap_color_test.sv
// ----------------------------------------------------------------------------
// value_to_hue_heatmap_color_test
// Drives the heat-map color block with directed samples at the range ends
// and with phases of random samples under changing range registers, with
// and without request gaps and result back-pressure, and gives the verdict.
// ----------------------------------------------------------------------------
module value_to_hue_heatmap_color_test;
   import hhc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 136;

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [CSR_INDEX_BITS-1:0]          csr_index;
   logic [SAMPLE_BITS_DEF-1:0]         csr_wdata;
   logic                               req_valid;
   logic                               req_ready;
   logic signed [SAMPLE_BITS_DEF-1:0]  req_sample;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [CHANNEL_BITS_DEF-1:0]        rsp_red;
   logic [CHANNEL_BITS_DEF-1:0]        rsp_green;
   logic [CHANNEL_BITS_DEF-1:0]        rsp_blue;
   int                                 errors;
   int                                 pending;
   int                                 colored;
   int                                 grays;
   int                                 cycles;
   int                                 send_idle_pct;
   int                                 stall_pct;
   int                                 settings;

   value_to_hue_heatmap_color dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue)
   );

   value_to_hue_heatmap_color_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .errors     (errors),
      .pending    (pending),
      .colored    (colored),
      .grays      (grays)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_colors();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_range(input logic signed [SAMPLE_BITS_DEF-1:0] lo,
                              input logic signed [SAMPLE_BITS_DEF-1:0] hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_RANGE_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_RANGE_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings++;
   endtask

   function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample(input int lo,
                                                                    input int hi);
      int roll;
      int v;
      roll = $urandom_range(99);
      if (roll < 15 || lo >= hi) begin
         v = int'($urandom_range(65535)) - 32768;
      end else if (roll < 30) begin
         v = ((roll % 2) ? lo : hi) + int'($urandom_range(4)) - 2;
         if (v < -32768) v = -32768;
         if (v > 32767) v = 32767;
      end else begin
         v = lo + int'($urandom_range(hi - lo));
      end
      return SAMPLE_BITS_DEF'(v);
   endfunction

   initial begin
      logic signed [SAMPLE_BITS_DEF-1:0] boundary_samples[10];
      logic signed [SAMPLE_BITS_DEF-1:0] span_samples[6];
      int lo;
      int hi;
      int a;
      int b;
      int mode;
      boundary_samples = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd16383,
                           16'sd16384, 16'sd32766, 16'sd32767, 16'sd21845, -16'sd21846};
      span_samples     = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, -16'sd32767, 16'sd32766};
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= CSR_RANGE_LOW;
      csr_wdata     <= '0;
      req_valid     <= 1'b0;
      req_sample    <= '0;
      send_idle_pct <= 0;
      stall_pct     <= 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (boundary_samples[i]) send_sample(boundary_samples[i]);
      drain_colors();
      write_range(-16'sd32768, 16'sd32767);
      foreach (span_samples[i]) send_sample(span_samples[i]);
      drain_colors();
      write_range(16'sd100, 16'sd100);
      send_sample(16'sd100);
      send_sample(-16'sd32768);
      drain_colors();
      write_range(16'sd32767, -16'sd32768);
      send_sample(16'sd32767);
      send_sample(16'sd0);

      for (int p = 0; p < PHASES; p++) begin
         drain_colors();
         mode = p % 4;
         send_idle_pct <= (mode == 1) ? 54 : (mode == 3) ? 22 : 0;
         stall_pct     <= (mode == 2) ? 54 : (mode == 3) ? 22 : 0;
         a = int'($urandom_range(65535)) - 32768;
         b = int'($urandom_range(65535)) - 32768;
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         case (p)
            0: begin
               lo = -32768; hi = 32767;
            end
            1: begin
               hi = lo;
            end
            2: begin
               lo = 32767; hi = -32768;
            end
            3: begin
               lo = int'($urandom_range(65534)) - 32768; hi = lo + 1;
            end
            5: begin
               lo = 0; hi = 32767;
            end
            6: begin
               lo = int'($urandom_range(32000)) - 16000; hi = lo + int'($urandom_range(64, 2));
            end
            default: begin
            end
         endcase
         write_range(SAMPLE_BITS_DEF'(lo), SAMPLE_BITS_DEF'(hi));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) drain_colors();
            send_sample(pick_sample(lo, hi));
         end
      end

      drain_colors();
      repeat (30) @(posedge clock);
      if (pending != 0) $error("%0d colors never returned.", pending);
      $display("Colored %0d samples under %0d range settings, %0d of them gray.",
               colored, settings, grays);
      $display("Phases ran without gaps, with request gaps, with back-pressure and with both.");
      if (errors == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
